FILE: rtl/core/spmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_pkg
// Word types and field codes shared by the message queue core and its checker.
// ----------------------------------------------------------------------------
package spmq_pkg;

  typedef struct packed {
    logic        mode;
    logic [3:0]  process_id;
    logic [31:0] message_word;
    logic [1:0]  recipient_state;
  } spmq_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] message_out;
    logic [1:0]  wake_action;
  } spmq_rsp_t;

  localparam logic MODE_SEND = 1'b0;

  localparam logic [1:0] RS_FREE  = 2'd0;
  localparam logic [1:0] RS_WAIT  = 2'd1;
  localparam logic [1:0] RS_TIMED = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FREE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [1:0] WAKE_NONE   = 2'd0;
  localparam logic [1:0] WAKE_READY  = 2'd1;
  localparam logic [1:0] WAKE_CANCEL = 2'd2;

endpackage

FILE: rtl/core/spmq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module spmq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/spmq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_ctrl
// Sequencer that walks the slot and queue rams: clear pass, free-slot scan,
// tail walk, link update and head pop.
// ----------------------------------------------------------------------------
module spmq_ctrl
  import spmq_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int NUM_PROCS = 16,
  localparam int SW  = $clog2(NUM_SLOTS),
  localparam int PW  = $clog2(NUM_PROCS),
  localparam int SEW = SW + 34,
  localparam int QEW = SW + 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  spmq_req_t      req,
  output logic           ready,
  output logic           res_valid,
  output spmq_rsp_t      res,
  input  logic           res_take,
  output logic           s_we,
  output logic [SW-1:0]  s_waddr,
  output logic [SEW-1:0] s_wdata,
  output logic [SW-1:0]  s_raddr,
  input  logic [SEW-1:0] s_rdata,
  output logic           q_we,
  output logic [PW-1:0]  q_waddr,
  output logic [QEW-1:0] q_wdata,
  output logic [PW-1:0]  q_raddr,
  input  logic [QEW-1:0] q_rdata
);

  localparam int CLR_N = (NUM_SLOTS > NUM_PROCS) ? NUM_SLOTS : NUM_PROCS;
  localparam int CW    = $clog2(CLR_N);

  // slot entry: used, link valid, link index, data
  localparam int USED_B = SEW - 1;
  localparam int LV_B   = SEW - 2;
  localparam int LNK_HI = SEW - 3;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_SQ    = 9'b000001000,
    S_WALK  = 9'b000010000,
    S_NEW   = 9'b000100000,
    S_RQ    = 9'b001000000,
    S_RSLOT = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t      state, state_next;
  spmq_req_t   req_r, req_r_next;
  spmq_rsp_t   res_next;
  logic [SW-1:0] scan_idx, scan_idx_next;
  logic [SW-1:0] cur, cur_next;
  logic [SW:0]   steps, steps_next;
  logic [CW-1:0] clr_idx, clr_idx_next;
  logic [PW-1:0] qidx;
  logic [SW-1:0] link;

  assign qidx      = PW'(req_r.process_id);
  assign link      = s_rdata[LNK_HI -: SW];
  assign ready     = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next    = state;
    req_r_next    = req_r;
    res_next      = res;
    scan_idx_next = scan_idx;
    cur_next      = cur;
    steps_next    = steps;
    clr_idx_next  = clr_idx;
    s_we          = 1'b0;
    s_waddr       = cur;
    s_wdata       = s_rdata;
    s_raddr       = cur;
    q_we          = 1'b0;
    q_waddr       = qidx;
    q_wdata       = q_rdata;
    q_raddr       = qidx;
    case (state)
      S_CLEAR: begin
        s_we         = (32'(clr_idx) < NUM_SLOTS);
        s_waddr      = clr_idx[SW-1:0];
        s_wdata      = '0;
        q_we         = (32'(clr_idx) < NUM_PROCS);
        q_waddr      = clr_idx[PW-1:0];
        q_wdata      = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (32'(clr_idx) == CLR_N - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_raddr       = '0;
        q_raddr       = PW'(req.process_id);
        scan_idx_next = '0;
        if (req_valid) begin
          req_r_next = req;
          if (!(32'(req.process_id) < NUM_PROCS) ||
              (req.mode == MODE_SEND && req.recipient_state == RS_FREE)) begin
            res_next   = '{status: ST_FREE, message_out: '0, wake_action: WAKE_NONE};
            state_next = S_DONE;
          end else if (req.mode == MODE_SEND) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_RQ;
          end
        end
      end
      S_SCAN: begin
        if (!s_rdata[USED_B]) begin
          state_next = S_SQ;
        end else if (32'(scan_idx) == NUM_SLOTS - 1) begin
          res_next   = '{status: ST_FULL, message_out: '0, wake_action: WAKE_NONE};
          state_next = S_DONE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
          s_raddr       = scan_idx + 1'b1;
        end
      end
      S_SQ: begin
        if (q_rdata[SW]) begin
          s_raddr    = q_rdata[SW-1:0];
          cur_next   = q_rdata[SW-1:0];
          steps_next = '0;
          state_next = S_WALK;
        end else begin
          q_we       = 1'b1;
          q_wdata    = {1'b1, scan_idx};
          state_next = S_NEW;
        end
      end
      S_WALK: begin
        if (s_rdata[LV_B] && (32'(steps) < NUM_SLOTS)) begin
          cur_next   = link;
          s_raddr    = link;
          steps_next = steps + 1'b1;
        end else begin
          // hook the new slot onto the tail
          s_we       = 1'b1;
          s_waddr    = cur;
          s_wdata    = {s_rdata[USED_B], 1'b1, scan_idx, s_rdata[31:0]};
          state_next = S_NEW;
        end
      end
      S_NEW: begin
        s_we       = 1'b1;
        s_waddr    = scan_idx;
        s_wdata    = {1'b1, 1'b0, {SW{1'b0}}, req_r.message_word};
        res_next   = '{status: ST_OK, message_out: '0, wake_action: WAKE_NONE};
        if (req_r.recipient_state == RS_WAIT) begin
          res_next.wake_action = WAKE_READY;
        end else if (req_r.recipient_state == RS_TIMED) begin
          res_next.wake_action = WAKE_CANCEL;
        end
        state_next = S_DONE;
      end
      S_RQ: begin
        if (!q_rdata[SW]) begin
          res_next   = '{status: ST_EMPTY, message_out: '0, wake_action: WAKE_NONE};
          state_next = S_DONE;
        end else begin
          s_raddr    = q_rdata[SW-1:0];
          cur_next   = q_rdata[SW-1:0];
          state_next = S_RSLOT;
        end
      end
      S_RSLOT: begin
        s_we       = 1'b1;
        s_waddr    = cur;
        s_wdata    = {1'b0, s_rdata[LV_B:0]};
        q_we       = 1'b1;
        q_wdata    = {s_rdata[LV_B], link};
        res_next   = '{status: ST_OK, message_out: s_rdata[31:0], wake_action: WAKE_NONE};
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_r_next;
    res      <= res_next;
    scan_idx <= scan_idx_next;
    cur      <= cur_next;
    steps    <= steps_next;
  end

endmodule

FILE: rtl/core/shared_pool_message_queues_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_pool_message_queues_core
// Per-process message queues kept as linked lists in a shared slot pool.
// ----------------------------------------------------------------------------
// One word is worked on at a time. After reset a clearing pass over
// max(NUM_SLOTS, NUM_PROCS) entries runs before the first word is taken. A
// send scans the slot ram for the lowest free slot, one entry a cycle (up to
// NUM_SLOTS entries), reads the recipient's queue entry, follows its list to
// the tail, one link a cycle, then writes the new link and the new slot. A
// send that finds the pool full answers only after the scan has covered all
// NUM_SLOTS entries. A receive reads the queue head and then its slot; a
// rejected send answers straight from idle. The result sits in an output
// register, so the next word can be taken while a result waits.
// ----------------------------------------------------------------------------
module shared_pool_message_queues_core
  import spmq_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int NUM_PROCS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  spmq_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output spmq_rsp_t rsp
);

  localparam int SW  = $clog2(NUM_SLOTS);
  localparam int PW  = $clog2(NUM_PROCS);
  localparam int SEW = SW + 34;
  localparam int QEW = SW + 1;

  logic           ready;
  logic           res_valid;
  spmq_rsp_t      res;
  logic           res_take;
  logic           s_we;
  logic [SW-1:0]  s_waddr;
  logic [SEW-1:0] s_wdata;
  logic [SW-1:0]  s_raddr;
  logic [SEW-1:0] s_rdata;
  logic           q_we;
  logic [PW-1:0]  q_waddr;
  logic [QEW-1:0] q_wdata;
  logic [PW-1:0]  q_raddr;
  logic [QEW-1:0] q_rdata;

  assign req_stall = !ready;
  assign res_take  = !rsp_valid || !rsp_stall;

  spmq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(SEW)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  spmq_ram #(.DEPTH(NUM_PROCS), .WIDTH(QEW)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  spmq_ctrl #(.NUM_SLOTS(NUM_SLOTS), .NUM_PROCS(NUM_PROCS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .ready     (ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .s_we      (s_we),
    .s_waddr   (s_waddr),
    .s_wdata   (s_wdata),
    .s_raddr   (s_raddr),
    .s_rdata   (s_rdata),
    .q_we      (q_we),
    .q_waddr   (q_waddr),
    .q_wdata   (q_wdata),
    .q_raddr   (q_raddr),
    .q_rdata   (q_rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      rsp <= res;
    end
  end

endmodule

FILE: rtl/core/spmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_checker
// Port-level checks on the message queue core, bound to the top level.
// ----------------------------------------------------------------------------
module spmq_assertions
  import spmq_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input spmq_req_t req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input spmq_rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // one word in flight: the block is busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("word taken while previous one still in work");

  a_msg_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.message_out == '0))
    else $error("message returned with failing status");

  a_wake_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.wake_action == WAKE_NONE)
    else $error("wake requested on failing status");

  a_wake_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.wake_action == WAKE_NONE || rsp.wake_action == WAKE_READY ||
                   rsp.wake_action == WAKE_CANCEL))
    else $error("unknown wake code");

endmodule

bind shared_pool_message_queues_core spmq_assertions u_spmq_assertions (.*);
